/* rtl/assert_macros.svh */
// Assertion macros used by the verification checker of the filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the synchronous reset is applied.
`define SVF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define SVF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/svf_pkg.sv */
// Shared constants, types and saturation helper of the state-variable filter.
package svf_pkg;

  localparam int SVF_SAMPLE_BITS = 24;
  localparam int SVF_COEF_BITS   = 24;

  // Integrator states and internal responses are signed Q8.24.
  localparam int STATE_W    = 32;
  localparam int STATE_FRAC = 24;
  // Wide intermediate sums before saturation back to the state format.
  localparam int WIDE_W     = STATE_W + 8;

  localparam int SVF_DAMPING_RESET = 1482910;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF  = 2'd0,
    REG_DAMPING = 2'd1,
    REG_NORM    = 2'd2,
    REG_MODE    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_LOWPASS  = 2'd0,
    MODE_HIGHPASS = 2'd1,
    MODE_BANDPASS = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_MUL_S1G  = 4'd1,
    OP_MUL_S1R  = 4'd2,
    OP_SUB_D    = 4'd3,
    OP_MUL_DH   = 4'd4,
    OP_MUL_DL   = 4'd5,
    OP_HP       = 4'd6,
    OP_MUL_HPG  = 4'd7,
    OP_BP       = 4'd8,
    OP_MUL_BPG  = 4'd9,
    OP_LP       = 4'd10,
    OP_FINISH   = 4'd11
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } dp_cmd_t;

  // Clamp a wide signed value to the signed 32-bit state range.
  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [STATE_W-1:0] r;
    if ((&v[WIDE_W-1:STATE_W-1]) || !(|v[WIDE_W-1:STATE_W-1])) begin
      r = v[STATE_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* rtl/svf_ctrl.sv */
// Sequencer of the filter: steps the shared multiplier schedule and owns the output valid.
module svf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output svf_pkg::dp_cmd_t cmd
);
  import svf_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_G1   = 12'b0000_0000_0010,
    ST_R1   = 12'b0000_0000_0100,
    ST_D    = 12'b0000_0000_1000,
    ST_NH   = 12'b0000_0001_0000,
    ST_NL   = 12'b0000_0010_0000,
    ST_HP   = 12'b0000_0100_0000,
    ST_GH   = 12'b0000_1000_0000,
    ST_BP   = 12'b0001_0000_0000,
    ST_GB   = 12'b0010_0000_0000,
    ST_LP   = 12'b0100_0000_0000,
    ST_OUT  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   finish;

  // The last step may only run when the output register is free or drains now.
  assign finish    = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_G1;
        end
      end
      ST_G1: begin
        cmd.op    = OP_MUL_S1G;
        state_nxt = ST_R1;
      end
      ST_R1: begin
        cmd.op    = OP_MUL_S1R;
        state_nxt = ST_D;
      end
      ST_D: begin
        cmd.op    = OP_SUB_D;
        state_nxt = ST_NH;
      end
      ST_NH: begin
        cmd.op    = OP_MUL_DH;
        state_nxt = ST_NL;
      end
      ST_NL: begin
        cmd.op    = OP_MUL_DL;
        state_nxt = ST_HP;
      end
      ST_HP: begin
        cmd.op    = OP_HP;
        state_nxt = ST_GH;
      end
      ST_GH: begin
        cmd.op    = OP_MUL_HPG;
        state_nxt = ST_BP;
      end
      ST_BP: begin
        cmd.op    = OP_BP;
        state_nxt = ST_GB;
      end
      ST_GB: begin
        cmd.op    = OP_MUL_BPG;
        state_nxt = ST_LP;
      end
      ST_LP: begin
        cmd.op    = OP_LP;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (finish) begin
          cmd.op    = OP_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/svf_datapath.sv */
// Datapath of the filter: coefficient registers, integrators and one shared multiplier.
module svf_datapath #(
  parameter int SAMPLE_BITS = svf_pkg::SVF_SAMPLE_BITS,
  parameter int COEF_BITS   = svf_pkg::SVF_COEF_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  svf_pkg::dp_cmd_t                     cmd,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_in,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_out,
  output logic                                 out_clipped,
  input  logic                                 cfg_wr_en,
  input  logic [svf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [COEF_BITS-1:0]                 cfg_wdata
);
  import svf_pkg::*;

  localparam int CF     = COEF_BITS - 4;
  localparam int NORM_W = COEF_BITS - 3;
  localparam int MA_W   = STATE_W + 1;
  localparam int P_W    = MA_W + COEF_BITS + 1;
  localparam int FL_W   = P_W - CF;
  localparam int D_W    = STATE_W + 6;
  localparam int DL_W   = STATE_W;
  localparam int DH_W   = D_W - DL_W;
  localparam int ACC_W  = D_W + NORM_W + 1;
  localparam int SF     = SAMPLE_BITS - 1;
  localparam int LO_SH  = (SF < STATE_FRAC) ? (STATE_FRAC - SF) : 0;
  localparam int HI_SH  = (SF > STATE_FRAC) ? (SF - STATE_FRAC) : 0;

  localparam logic [COEF_BITS-1:0] DAMP_RESET = COEF_BITS'(SVF_DAMPING_RESET);
  localparam logic [NORM_W-1:0]    NORM_RESET = NORM_W'(1) << CF;

  logic [COEF_BITS-1:0] cutoff_r, cutoff_nxt;
  logic [COEF_BITS-1:0] damping_r, damping_nxt;
  logic [NORM_W-1:0]    norm_r, norm_nxt;
  logic [1:0]           mode_r, mode_nxt;

  logic signed [STATE_W-1:0] s1_r, s1_nxt;
  logic signed [STATE_W-1:0] s2_r, s2_nxt;

  logic signed [D_W-1:0]     x_r, x_nxt;
  logic signed [D_W-1:0]     d_r, d_nxt;
  logic signed [P_W-1:0]     p_r, p_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [STATE_W-1:0] hp_r, hp_nxt;
  logic signed [STATE_W-1:0] bp_r, bp_nxt;
  logic signed [STATE_W-1:0] lp_r, lp_nxt;
  logic signed [FL_W-1:0]    gp_r, gp_nxt;
  logic signed [SAMPLE_BITS-1:0] y_r, y_nxt;
  logic                      clip_r, clip_nxt;

  logic signed [MA_W-1:0]    mul_a;
  logic [COEF_BITS-1:0]      mul_b;
  logic signed [DH_W-1:0]    d_hi;
  logic signed [FL_W-1:0]    p_fl;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [D_W-1:0]     x_ext;
  logic signed [STATE_W-1:0] sel;
  logic signed [WIDE_W-1:0]  sel_ext;
  logic signed [WIDE_W-1:0]  y_wide;
  logic                      y_over;

  assign d_hi    = d_r[D_W-1:DL_W];
  // Product rounded toward minus infinity to the state's fraction bits.
  assign p_fl    = FL_W'(p_r >>> CF);
  assign acc_sum = acc_r + ACC_W'(p_r);
  assign x_ext   = D_W'(in_sample_in);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = MA_W'(s1_r);
    mul_b = cutoff_r;
    case (cmd.op)
      OP_MUL_S1R: mul_b = damping_r;
      OP_MUL_DH: begin
        mul_a = MA_W'(d_hi);
        mul_b = COEF_BITS'(norm_r);
      end
      OP_MUL_DL: begin
        mul_a = MA_W'({1'b0, d_r[DL_W-1:0]});
        mul_b = COEF_BITS'(norm_r);
      end
      OP_MUL_HPG: mul_a = MA_W'(hp_r);
      OP_MUL_BPG: mul_a = MA_W'(bp_r);
      default: ;
    endcase
  end

  assign p_nxt = P_W'(mul_a) * P_W'($signed({1'b0, mul_b}));

  // Response selection and conversion to the sample format.
  always_comb begin
    case (mode_r)
      MODE_HIGHPASS: sel = hp_r;
      MODE_BANDPASS: sel = bp_r;
      default:       sel = lp_r;
    endcase
  end

  assign sel_ext = WIDE_W'(sel);
  assign y_wide  = (sel_ext <<< HI_SH) >>> LO_SH;
  assign y_over  = !((&y_wide[WIDE_W-1:SF]) || !(|y_wide[WIDE_W-1:SF]));

  always_comb begin
    x_nxt    = x_r;
    d_nxt    = d_r;
    acc_nxt  = acc_r;
    hp_nxt   = hp_r;
    bp_nxt   = bp_r;
    lp_nxt   = lp_r;
    gp_nxt   = gp_r;
    s1_nxt   = s1_r;
    s2_nxt   = s2_r;
    y_nxt    = y_r;
    clip_nxt = clip_r;
    if (cmd.capture) begin
      x_nxt = (x_ext <<< LO_SH) >>> HI_SH;
    end
    case (cmd.op)
      OP_MUL_S1R: d_nxt = x_r - D_W'(s2_r) - D_W'(p_fl);
      OP_SUB_D:   d_nxt = d_r - D_W'(p_fl);
      OP_MUL_DL:  acc_nxt = ACC_W'(p_r) <<< DL_W;
      OP_HP:      hp_nxt = sat_state(WIDE_W'(acc_sum >>> CF));
      OP_BP: begin
        gp_nxt = p_fl;
        bp_nxt = sat_state(WIDE_W'(p_fl) + WIDE_W'(s1_r));
      end
      OP_MUL_BPG: s1_nxt = sat_state(WIDE_W'(gp_r) + WIDE_W'(bp_r));
      OP_LP: begin
        gp_nxt = p_fl;
        lp_nxt = sat_state(WIDE_W'(p_fl) + WIDE_W'(s2_r));
      end
      OP_FINISH: begin
        s2_nxt   = sat_state(WIDE_W'(gp_r) + WIDE_W'(lp_r));
        clip_nxt = y_over;
        if (y_over) begin
          y_nxt = {y_wide[WIDE_W-1], {(SAMPLE_BITS-1){~y_wide[WIDE_W-1]}}};
        end else begin
          y_nxt = y_wide[SAMPLE_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cutoff_nxt  = cutoff_r;
    damping_nxt = damping_r;
    norm_nxt    = norm_r;
    mode_nxt    = mode_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_CUTOFF:  cutoff_nxt  = cfg_wdata;
        REG_DAMPING: damping_nxt = cfg_wdata;
        REG_NORM:    norm_nxt    = cfg_wdata[NORM_W-1:0];
        REG_MODE:    mode_nxt    = cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r  <= '0;
      damping_r <= DAMP_RESET;
      norm_r    <= NORM_RESET;
      mode_r    <= MODE_LOWPASS;
      s1_r      <= '0;
      s2_r      <= '0;
    end else begin
      cutoff_r  <= cutoff_nxt;
      damping_r <= damping_nxt;
      norm_r    <= norm_nxt;
      mode_r    <= mode_nxt;
      s1_r      <= s1_nxt;
      s2_r      <= s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    d_r    <= d_nxt;
    p_r    <= p_nxt;
    acc_r  <= acc_nxt;
    hp_r   <= hp_nxt;
    bp_r   <= bp_nxt;
    lp_r   <= lp_nxt;
    gp_r   <= gp_nxt;
    y_r    <= y_nxt;
    clip_r <= clip_nxt;
  end

  assign out_sample_out = y_r;
  assign out_clipped    = clip_r;

endmodule

/* rtl/state_variable_filter_top.sv */
// Top level of the second-order trapezoidal state-variable filter.
// The sequencer takes one sample at a time, and its rate is set by the single shared
// multiplier, which forms six dependent products per sample (the normalization product
// in two halves).
// Reset (synchronous, active low) clears both integrators, the output valid and the
// sequencer, and loads the coefficient registers with their default values.
module state_variable_filter_top #(
  parameter int SAMPLE_BITS = svf_pkg::SVF_SAMPLE_BITS,
  parameter int COEF_BITS   = svf_pkg::SVF_COEF_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_clipped,
  input  logic                          cfg_wr_en,
  input  logic [svf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_wdata
);
  import svf_pkg::*;

  // Command bundle from the sequencer to the datapath. Each sequencer state
  // issues one datapath operation; the multiplier product is registered and
  // consumed by the following state, so the schedule is:
  //   s1*g, s1*r, finish the difference d, high and low halves of d*a0,
  //   highpass, hp*g, bandpass, bp*g (with the first integrator update),
  //   lowpass, and finally the second integrator update and the output.
  dp_cmd_t cmd;

  // The sequencer takes a new input transfer only when it is idle. The output
  // register holds a finished result while the next sample is already being
  // worked on; the last step waits only if that register is still occupied.
  svf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath keeps both integrators, the result and the coefficient registers; software
  // is to write those only while the filter is idle, and the block does not enforce this.
  svf_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_sample_in   (in_sample_in),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

endmodule

/* rtl/svf_checker.sv */
// Port-level checker of the state-variable filter and its bind to the top level.
`include "assert_macros.svh"

module svf_checker #(
  parameter int SAMPLE_BITS = svf_pkg::SVF_SAMPLE_BITS
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_sample_out,
  input logic                   out_clipped
);

  // Reset leaves the filter empty and ready for a sample.
  `SVF_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!out_valid && !in_stall), "reset state")

  // One sample at a time: a transfer on the input makes the block busy.
  `SVF_ASSERT(a_busy_after_in, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "not busy")

  // A new result can only appear at the end of work on a sample.
  `SVF_ASSERT(a_result_from_work, clk, rst_n, $rose(out_valid) |-> $past(in_stall), "no work")

  // A clipped result carries the full-scale value of its sign.
  `SVF_ASSERT(a_clip_fullscale, clk, rst_n, (out_valid && out_clipped) |-> (out_sample_out[SAMPLE_BITS-1] ? (out_sample_out[SAMPLE_BITS-2:0] == '0) : (&out_sample_out[SAMPLE_BITS-2:0])), "clip value")

  // A stalled result holds.
  `SVF_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_sample_out) && $stable(out_clipped)), "result changed")

endmodule

bind state_variable_filter_top svf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_svf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out),
  .out_clipped    (out_clipped)
);
